// File: sv/vertex_dedup_pool_unit_defines.svh
// Assertion macros shared by the vertex pool RTL.
`ifndef VERTEX_DEDUP_POOL_UNIT_DEFINES_SVH
`define VERTEX_DEDUP_POOL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define VDP_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("vertex pool assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define VDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vertex pool assertion failed");
`else
`define VDP_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define VDP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/vdp_pkg.sv
// Types and constants of the vertex dedup pool.
`default_nettype none

package vdp_pkg;

    localparam int POOL_DEPTH_DEF = 64;

    localparam int REQ_W    = 2;
    localparam int WORD_W   = 32;
    localparam int RIDX_W   = 6;
    localparam int STATUS_W = 3;
    localparam int EIDX_W   = 6;
    localparam int ECNT_W   = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req_e;

    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED    = 3'd0,
        STS_FOUND    = 3'd1,
        STS_FULL     = 3'd2,
        STS_READ_OK  = 3'd3,
        STS_READ_OOR = 3'd4,
        STS_CLEARED  = 3'd5
    } t_status_e;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] t;
    } t_vertex;

    typedef struct packed {
        t_status_e         status;
        logic [EIDX_W-1:0] idx;
        t_vertex           data;
        logic [ECNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

// File: sv/vdp_in_if.sv
// Request channel of the vertex dedup pool.
`default_nettype none

interface vdp_in_if;
    logic                          valid;
    logic                          ready;
    logic [vdp_pkg::REQ_W-1:0]     req_type;
    logic [vdp_pkg::WORD_W-1:0]    pos_x;
    logic [vdp_pkg::WORD_W-1:0]    pos_y;
    logic [vdp_pkg::WORD_W-1:0]    pos_z;
    logic [vdp_pkg::WORD_W-1:0]    tex_s;
    logic [vdp_pkg::WORD_W-1:0]    tex_t;
    logic [vdp_pkg::RIDX_W-1:0]    read_index;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, tex_s, tex_t, read_index,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, tex_s, tex_t, read_index,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/vdp_out_if.sv
// Result channel of the vertex dedup pool.
`default_nettype none

interface vdp_out_if;
    logic                          valid;
    logic                          ready;
    logic [vdp_pkg::STATUS_W-1:0]  status;
    logic [vdp_pkg::EIDX_W-1:0]    entry_index;
    logic [vdp_pkg::WORD_W-1:0]    out_x;
    logic [vdp_pkg::WORD_W-1:0]    out_y;
    logic [vdp_pkg::WORD_W-1:0]    out_z;
    logic [vdp_pkg::WORD_W-1:0]    out_s;
    logic [vdp_pkg::WORD_W-1:0]    out_t;
    logic [vdp_pkg::ECNT_W-1:0]    entry_count;

    modport source (
        output valid, status, entry_index, out_x, out_y, out_z, out_s, out_t,
               entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, out_x, out_y, out_z, out_s, out_t,
               entry_count,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/vdp_store.sv
// Vertex storage: one write port, one read port with registered data.
`default_nettype none

module vdp_store #(
    parameter int POOL_DEPTH = vdp_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(POOL_DEPTH)-1:0] i_waddr,
    input  wire vdp_pkg::t_vertex              i_wdata,
    input  wire logic                          i_re,
    input  wire logic [$clog2(POOL_DEPTH)-1:0] i_raddr,
    output vdp_pkg::t_vertex                   o_rdata
);

    vdp_pkg::t_vertex r_mem [POOL_DEPTH];
    vdp_pkg::t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/vdp_match.sv
// Shared five-word compare unit used by the scan.
`default_nettype none

module vdp_match (
    input  wire logic             i_en,
    input  wire vdp_pkg::t_vertex i_key,
    input  wire vdp_pkg::t_vertex i_entry,
    output logic                  o_hit
);

    logic w_pos_eq;
    logic w_tex_eq;

    // exact bit-pattern match, no float semantics
    assign w_pos_eq = (i_key.x == i_entry.x) && (i_key.y == i_entry.y) &&
                      (i_key.z == i_entry.z);
    assign w_tex_eq = (i_key.s == i_entry.s) && (i_key.t == i_entry.t);
    assign o_hit    = i_en && w_pos_eq && w_tex_eq;

endmodule

`default_nettype wire

// File: sv/vertex_dedup_pool_unit.sv
// Top level of the vertex dedup pool: sequencer, store and compare unit.
// Keeps up to POOL_DEPTH unique vertices (five raw 32-bit words each). An add
// beat is matched against stored entries one per cycle, lowest index first,
// through a single compare unit fed by the store's read port; a hit returns
// the existing index, a miss appends at the next free index, or reports full.
// An add steps through the entries one per cycle via the registered store
// read port; a read makes one registered memory read before its result; a
// clear or an out-of-range read is answered straight from the idle state.
// One request is in flight at a time; the request channel is ready
// whenever the sequencer is idle and the result register is free or being
// drained in that cycle. Request code 3 is dropped with no result. Clear
// only zeroes the entry count; stored words are left in place and are never
// compared or read past the count, so the store needs no clearing pass.
// entry_index and entry_count carry the low 6 and 7 bits of the internal
// index and count.
`default_nettype none
`include "vertex_dedup_pool_unit_defines.svh"

module vertex_dedup_pool_unit #(
    parameter int POOL_DEPTH = vdp_pkg::POOL_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vdp_in_if.sink     i_in,
    vdp_out_if.source  o_out
);

    localparam int IW   = $clog2(POOL_DEPTH);
    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int CMPW = (CW > vdp_pkg::RIDX_W) ? CW : vdp_pkg::RIDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_DATA
    } t_state_e;

    // sequencer state
    t_state_e                   r_state,    n_state;
    logic [CW-1:0]              r_count,    n_count;
    logic [CW-1:0]              r_issue,    n_issue;     // next entry to read
    logic                       r_pend,     n_pend;      // read data due this cycle
    logic [IW-1:0]              r_pend_addr, n_pend_addr;
    vdp_pkg::t_vertex           r_key,      n_key;
    logic [vdp_pkg::RIDX_W-1:0] r_ri,       n_ri;
    logic                       r_out_vld,  n_out_vld;
    vdp_pkg::t_result           r_out,      n_out;

    // store ports
    logic                       w_we;
    logic [IW-1:0]              w_waddr;
    logic                       w_re;
    logic [IW-1:0]              w_raddr;
    vdp_pkg::t_vertex           w_rdata;
    logic                       w_hit;

    logic                       w_in_acc;
    logic                       w_out_take;
    vdp_pkg::t_vertex           w_in_vtx;

    assign w_in_vtx = '{x: i_in.pos_x, y: i_in.pos_y, z: i_in.pos_z,
                        s: i_in.tex_s, t: i_in.tex_t};

    assign w_out_take = r_out_vld && o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_vld || o_out.ready);
    assign w_in_acc   = i_in.valid && i_in.ready;

    vdp_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vdp_match u_match (
        .i_en    (r_pend),
        .i_key   (r_key),
        .i_entry (w_rdata),
        .o_hit   (w_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_key       = r_key;
        n_ri        = r_ri;
        n_out_vld   = r_out_vld && !w_out_take;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_count[IW-1:0];
        w_re        = 1'b0;
        w_raddr     = r_issue[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.req_type)
                        vdp_pkg::REQ_ADD: begin
                            n_key   = w_in_vtx;
                            n_issue = '0;
                            n_pend  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        vdp_pkg::REQ_READ: begin
                            n_ri = i_in.read_index;
                            if (CMPW'(i_in.read_index) < CMPW'(r_count)) begin
                                w_re    = 1'b1;
                                w_raddr = IW'(i_in.read_index);
                                n_state = ST_RD_DATA;
                            end else begin
                                n_out_vld = 1'b1;
                                n_out     = '{status: vdp_pkg::STS_READ_OOR,
                                              idx: '0, data: '0,
                                              count: vdp_pkg::ECNT_W'(r_count)};
                            end
                        end
                        vdp_pkg::REQ_CLEAR: begin
                            n_count   = '0;
                            n_out_vld = 1'b1;
                            n_out     = '{status: vdp_pkg::STS_CLEARED,
                                          idx: '0, data: '0, count: '0};
                        end
                        default: begin
                            // unused code: dropped, no result
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (w_hit) begin
                    // first hit in index order is the lowest match
                    n_pend    = 1'b0;
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    n_out     = '{status: vdp_pkg::STS_FOUND,
                                  idx: vdp_pkg::EIDX_W'(r_pend_addr), data: '0,
                                  count: vdp_pkg::ECNT_W'(r_count)};
                end else if (r_issue < r_count) begin
                    w_re        = 1'b1;
                    w_raddr     = r_issue[IW-1:0];
                    n_issue     = r_issue + CW'(1);
                    n_pend      = 1'b1;
                    n_pend_addr = r_issue[IW-1:0];
                end else begin
                    // all entries compared, none matched
                    n_pend    = 1'b0;
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    if (r_count == CW'(POOL_DEPTH)) begin
                        n_out = '{status: vdp_pkg::STS_FULL, idx: '0, data: '0,
                                  count: vdp_pkg::ECNT_W'(r_count)};
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IW-1:0];
                        n_count = r_count + CW'(1);
                        n_out   = '{status: vdp_pkg::STS_ADDED,
                                    idx: vdp_pkg::EIDX_W'(r_count), data: '0,
                                    count: vdp_pkg::ECNT_W'(r_count + CW'(1))};
                    end
                end
            end

            ST_RD_DATA: begin
                n_state   = ST_IDLE;
                n_out_vld = 1'b1;
                n_out     = '{status: vdp_pkg::STS_READ_OK, idx: r_ri,
                              data: w_rdata, count: vdp_pkg::ECNT_W'(r_count)};
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_issue   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
        r_pend_addr <= n_pend_addr;
        r_key       <= n_key;
        r_ri        <= n_ri;
        r_out       <= n_out;
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.status      = r_out.status;
    assign o_out.entry_index = r_out.idx;
    assign o_out.out_x       = r_out.data.x;
    assign o_out.out_y       = r_out.data.y;
    assign o_out.out_z       = r_out.data.z;
    assign o_out.out_s       = r_out.data.s;
    assign o_out.out_t       = r_out.data.t;
    assign o_out.entry_count = r_out.count;

    // count never runs past the pool size
    `VDP_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(POOL_DEPTH))
    // appends only land in a free slot
    `VDP_ASSERT_ALWAYS(a_write_free, i_clk, i_rst_n, !w_we || (r_count < CW'(POOL_DEPTH)))
    // no result waits while a request is still being worked on
    `VDP_ASSERT_ALWAYS(a_busy_no_out, i_clk, i_rst_n, (r_state == ST_IDLE) || !r_out_vld)
    // a clear beat leaves the pool empty
    `VDP_ASSERT_NEXT(a_clear_empty, i_clk, i_rst_n,
        w_in_acc && (i_in.req_type == vdp_pkg::REQ_CLEAR), r_count == '0)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench of the vertex dedup pool: queued requests, pool predictor, result checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vdp_pkg::*;

    localparam int POOL_DEPTH = POOL_DEPTH_DEF;
    // Request code the block drops without a result.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    // One long back-pressure window on the result side, after this many results.
    localparam int HOLD_AFTER   = 60;
    localparam int LONG_HOLD    = 400;
    // Extra wait at the end, scaled with the pool depth to outlast the longest add scan.
    localparam int DRAIN_CYCLES = POOL_DEPTH + 16;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        t_vertex           vtx;
        logic [RIDX_W-1:0] ridx;
    } t_pool_req;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_THIRD,
        STALL_QUARTER
    } t_stall_e;

    logic i_clk;
    logic i_rst_n;

    vdp_in_if  req_if ();
    vdp_out_if rsp_if ();

    vertex_dedup_pool_unit #(
        .POOL_DEPTH (POOL_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Requests waiting for the driver, and results owed by the block.
    t_pool_req request_q[$];
    t_result   result_due_q[$];

    // Predicted pool contents.
    t_vertex pool_vtx[POOL_DEPTH];
    int      pool_used;

    bit failed;
    int total_requests;
    int beats_sent;
    int queued_items;
    int cycle_cnt;

    // Driver side.
    t_pool_req on_bus;
    int        burst_left;
    int        gap_left;

    // Receiver side.
    t_stall_e stall_mode;
    int       stall_tick;
    int       hold_left;
    bit       hold_done;
    int       results_seen;

    // Generator bookkeeping: the last 256 vertices offered and a rough fill estimate.
    t_vertex sent_hist[$];
    int      gen_used;

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pool predictor: updates the pool copy and queues the owed result.
    // ------------------------------------------------------------------
    task automatic pool_predict(input t_pool_req r);
        t_result res;
        bit      hit;
        int      hit_idx;
        res     = '0;
        hit     = 1'b0;
        hit_idx = 0;
        case (r.req)
            REQ_ADD: begin
                // Lowest matching entry wins; only live entries take part.
                for (int j = 0; j < pool_used; j++) begin
                    if (!hit && pool_vtx[j] == r.vtx) begin
                        hit     = 1'b1;
                        hit_idx = j;
                    end
                end
                if (hit) begin
                    res.status = STS_FOUND;
                    res.idx    = EIDX_W'(hit_idx);
                end else if (pool_used >= POOL_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    pool_vtx[pool_used] = r.vtx;
                    res.status          = STS_ADDED;
                    res.idx             = EIDX_W'(pool_used);
                    pool_used++;
                end
            end
            REQ_READ: begin
                if (int'(r.ridx) < pool_used) begin
                    res.status = STS_READ_OK;
                    res.idx    = r.ridx;
                    res.data   = pool_vtx[r.ridx];
                end else begin
                    res.status = STS_READ_OOR;
                end
            end
            REQ_CLEAR: begin
                // Stored words stay behind but are dead from here on.
                pool_used  = 0;
                res.status = STS_CLEARED;
            end
            default: begin
                // Unused code: no result, no state change.
                return;
            end
        endcase
        res.count = ECNT_W'(pool_used);
        result_due_q.insert(result_due_q.size(), res);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Corner words show up often so all-zero and all-one fields recur.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex v;
        v.x = pick_word();
        v.y = pick_word();
        v.z = pick_word();
        v.s = pick_word();
        v.t = pick_word();
        return v;
    endfunction

    task automatic push_req(input logic [REQ_W-1:0] req, input t_vertex vtx,
                            input logic [RIDX_W-1:0] ridx);
        t_pool_req r;
        r.req  = req;
        r.vtx  = vtx;
        r.ridx = ridx;
        request_q.insert(request_q.size(), r);
        if (req != REQ_UNUSED)
            queued_items++;
    endtask

    // New vertex; some are one-bit neighbors of an earlier one so the exact
    // five-word compare gets exercised on every bit.
    task automatic add_fresh();
        t_vertex v;
        if (sent_hist.size() != 0 && $urandom_range(0, 9) < 3) begin
            v = sent_hist[$urandom_range(0, sent_hist.size() - 1)];
            v[$urandom_range(0, 5 * WORD_W - 1)] ^= 1'b1;
        end else begin
            v = rand_vertex();
        end
        push_req(REQ_ADD, v, RIDX_W'($urandom));
        sent_hist.insert(sent_hist.size(), v);
        if (sent_hist.size() > 256)
            void'(sent_hist.pop_front());
        if (gen_used < POOL_DEPTH)
            gen_used++;
    endtask

    // Re-offer an earlier vertex: a hit if still live, a fresh add if cleared.
    task automatic add_repeat();
        if (sent_hist.size() == 0) begin
            add_fresh();
        end else begin
            push_req(REQ_ADD, sent_hist[$urandom_range(0, sent_hist.size() - 1)],
                     RIDX_W'($urandom));
        end
    endtask

    task automatic read_some();
        logic [RIDX_W-1:0] ridx;
        if (gen_used > 0 && $urandom_range(0, 9) < 7)
            ridx = RIDX_W'($urandom_range(0, gen_used - 1));
        else
            ridx = RIDX_W'($urandom_range(0, POOL_DEPTH - 1));
        push_req(REQ_READ, rand_vertex(), ridx);
    endtask

    task automatic clear_pool();
        push_req(REQ_CLEAR, rand_vertex(), RIDX_W'($urandom));
        gen_used = 0;
    endtask

    // One round of traffic, always closed by a clear. A fill round keeps
    // adding new vertices until the pool has overflowed by a few.
    task automatic run_round(input bit fill_up);
        int fresh_left;
        int ops;
        int roll;
        fresh_left = fill_up ? POOL_DEPTH + $urandom_range(2, 8) : 0;
        ops        = fill_up ? 0 : $urandom_range(6, 40);
        while (fresh_left > 0 || ops > 0) begin
            roll = $urandom_range(0, 99);
            if (fill_up) begin
                if (roll < 75) begin
                    add_fresh();
                    fresh_left--;
                end else if (roll < 88) begin
                    add_repeat();
                end else begin
                    read_some();
                end
            end else begin
                ops--;
                if (roll < 40)
                    add_fresh();
                else if (roll < 60)
                    add_repeat();
                else if (roll < 88)
                    read_some();
                else if (roll < 94)
                    push_req(REQ_UNUSED, rand_vertex(), RIDX_W'($urandom));
                else
                    clear_pool();
            end
        end
        clear_pool();
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, fed from request_q.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                pool_predict(on_bus);
                beats_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    on_bus = request_q.pop_front();
                    burst_left--;
                    req_if.req_type   <= on_bus.req;
                    req_if.pos_x      <= on_bus.vtx.x;
                    req_if.pos_y      <= on_bus.vtx.y;
                    req_if.pos_z      <= on_bus.vtx.z;
                    req_if.tex_s      <= on_bus.vtx.s;
                    req_if.tex_t      <= on_bus.vtx.t;
                    req_if.read_index <= on_bus.ridx;
                    req_if.valid      <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_mon
        t_result due;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_seen++;
                if (result_due_q.size() == 0) begin
                    $error("result beat with nothing owed: status %0d index %0d",
                           rsp_if.status, rsp_if.entry_index);
                    failed = 1'b1;
                end else begin
                    due = result_due_q.pop_front();
                    check_field("status", due.status, rsp_if.status);
                    check_field("entry_index", due.idx, rsp_if.entry_index);
                    check_field("out_x", due.data.x, rsp_if.out_x);
                    check_field("out_y", due.data.y, rsp_if.out_y);
                    check_field("out_z", due.data.z, rsp_if.out_z);
                    check_field("out_s", due.data.s, rsp_if.out_s);
                    check_field("out_t", due.data.t, rsp_if.out_t);
                    check_field("entry_count", due.count, rsp_if.entry_count);
                end
            end

            // Long hold once: the sender keeps offering, so the block backs up
            // and has to drop its request ready.
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (stall_tick == 0) begin
                stall_mode = t_stall_e'($urandom_range(0, 3));
                stall_tick = $urandom_range(8, 48);
            end
            stall_tick--;

            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    STALL_NONE:  rsp_if.ready <= 1'b1;
                    STALL_HALF:  rsp_if.ready <= 1'($urandom_range(0, 1));
                    STALL_THIRD: rsp_if.ready <= (stall_tick % 3 != 0);
                    default:     rsp_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $error("timeout: %0d of %0d requests sent, %0d results outstanding",
                   beats_sent, total_requests, result_due_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin : main_seq
        t_vertex v;

        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_ADD;
        req_if.pos_x         = '0;
        req_if.pos_y         = '0;
        req_if.pos_z         = '0;
        req_if.tex_s         = '0;
        req_if.tex_t         = '0;
        req_if.read_index    = '0;
        rsp_if.ready         = 1'b0;
        failed               = 1'b0;
        pool_used            = 0;
        beats_sent           = 0;
        cycle_cnt            = 0;
        burst_left           = 0;
        gap_left             = 0;
        stall_mode           = STALL_NONE;
        stall_tick           = 0;
        hold_left            = 0;
        hold_done            = 1'b0;
        results_seen         = 0;
        gen_used             = 0;
        queued_items         = 0;

        // Directed: empty pool, corner words, hits, near misses, reads at and
        // past the count, the dropped code, and stale entries after a clear.
        push_req(REQ_READ, '0, '0);                 // read on empty pool
        push_req(REQ_CLEAR, '1, '1);                // clear on empty pool
        push_req(REQ_ADD, '0, '1);                  // all-zero vertex -> 0
        push_req(REQ_ADD, '1, '0);                  // all-one vertex -> 1
        push_req(REQ_ADD, '0, '0);                  // hit on 0
        push_req(REQ_ADD, '1, '1);                  // hit on 1
        v = '1;
        v.t[0] = 1'b0;
        push_req(REQ_ADD, v, '0);                   // differs in last bit -> 2
        v = '0;
        v.x[WORD_W-1] = 1'b1;
        push_req(REQ_ADD, v, '0);                   // differs in first bit -> 3
        push_req(REQ_READ, '1, 6'd0);
        push_req(REQ_READ, '0, 6'd1);
        push_req(REQ_READ, '0, 6'd3);
        push_req(REQ_READ, '0, 6'd4);               // index equal to count
        push_req(REQ_READ, '0, '1);                 // top index
        push_req(REQ_UNUSED, '1, '1);               // dropped, no result
        v.x = 32'hAAAA_AAAA;
        v.y = 32'h5555_5555;
        v.z = 32'hAAAA_AAAA;
        v.s = 32'h5555_5555;
        v.t = 32'hAAAA_AAAA;
        push_req(REQ_ADD, v, '0);                   // -> 4
        push_req(REQ_READ, '0, 6'd4);
        push_req(REQ_CLEAR, '0, '0);
        push_req(REQ_ADD, '1, '0);                  // stale 1 not matched -> 0
        push_req(REQ_READ, '0, 6'd1);               // stale entry not readable
        push_req(REQ_READ, '0, 6'd0);
        push_req(REQ_CLEAR, '0, '0);

        // Random: open with a fill round (full pool, hits while full, widest
        // index and count), then mostly short rounds with the odd fill.
        queued_items = 0;
        run_round(1'b1);
        while (queued_items < RANDOM_ITEMS)
            run_round($urandom_range(0, 5) == 0);
        total_requests = request_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (beats_sent == total_requests);
        while (result_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/vdp_pkg.sv
sv/vdp_in_if.sv
sv/vdp_out_if.sv
sv/vdp_store.sv
sv/vdp_match.sv
sv/vertex_dedup_pool_unit.sv
tb/sv/tb_top.sv
